@@ hdl/ftr_pkg.sv @@
`default_nettype none

package ftr_pkg;

    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 256;

    localparam int COORD_W = 11;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = PROD_W + 1;
    localparam int EDGE_W  = PROD_W + 2;
    localparam int COLOR_W = 32;
    localparam int READ_W  = 8;

    localparam int XW        = $clog2(FRAME_WIDTH);
    localparam int YW        = $clog2(FRAME_HEIGHT);
    localparam int MEM_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COLOR_W-1:0] PIX_WHITE = '1;
    localparam logic [COLOR_W-1:0] PIX_CLEAR = '0;

    typedef enum logic [0:0] {
        MODE_DRAW = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t FRAME_X_MAX = coord_t'(FRAME_WIDTH - 1);
    localparam coord_t FRAME_Y_MAX = coord_t'(FRAME_HEIGHT - 1);

    // decoded command handed from the front end to the back end
    typedef struct packed {
        logic               is_read;
        logic               culled;
        logic               box_empty;
        logic [READ_W-1:0]  read_x;
        logic [READ_W-1:0]  read_y;
        coord_t             ax;
        coord_t             ay;
        coord_t             bx;
        coord_t             by;
        coord_t             cx;
        coord_t             cy;
        coord_t             x0;
        coord_t             x1;
        coord_t             y0;
        coord_t             y1;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [XW-1:0] x,
                                                   input logic [YW-1:0] y);
        return ADDR_W'(int'(y) * FRAME_WIDTH + int'(x));
    endfunction

    function automatic logic in_frame(input coord_t x, input coord_t y);
        return (x >= 0) && (int'(x) < FRAME_WIDTH) &&
               (y >= 0) && (int'(y) < FRAME_HEIGHT);
    endfunction

    function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ftr_req_if.sv @@
`default_nettype none

interface ftr_req_if;
    import ftr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    coord_t                ax;
    coord_t                ay;
    coord_t                bx;
    coord_t                by;
    coord_t                cx;
    coord_t                cy;
    logic [COLOR_W-1:0]    fill_color;
    logic [READ_W-1:0]     read_x;
    logic [READ_W-1:0]     read_y;

    modport source (
        output valid, mode, ax, ay, bx, by, cx, cy, fill_color, read_x, read_y,
        input  ready
    );

    modport sink (
        input  valid, mode, ax, ay, bx, by, cx, cy, fill_color, read_x, read_y,
        output ready
    );

endinterface

`default_nettype wire

@@ hdl/ftr_rsp_if.sv @@
`default_nettype none

interface ftr_rsp_if;
    import ftr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_color;
    logic               was_culled;

    modport source (
        output valid, read_color, was_culled,
        input  ready
    );

    modport sink (
        input  valid, read_color, was_culled,
        output ready
    );

endinterface

`default_nettype wire

@@ hdl/ftr_front.sv @@
`default_nettype none

module ftr_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ftr_req_if.sink              req,
    input  wire logic            clearing,
    input  wire ftr_pkg::q_stat_t q_stat,
    output logic                 push,
    output ftr_pkg::cmd_t        push_cmd
);
    import ftr_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_PROD_A = 4'b0010,
        F_PROD_B = 4'b0100,
        F_PUSH   = 4'b1000
    } fstate_t;

    fstate_t                   state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [PROD_W-1:0]  prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0]  prod_b_reg, prod_b_next;

    logic signed [DIFF_W-1:0]  d_bax, d_cay, d_cax, d_bay;
    logic signed [AREA_W-1:0]  area;
    coord_t                    xmin, xmax, ymin, ymax;
    coord_t                    x0c, x1c, y0c, y1c;

    assign req.ready = (state_reg == F_IDLE) && !clearing;

    assign d_bax = DIFF_W'(cmd_reg.bx) - DIFF_W'(cmd_reg.ax);
    assign d_cay = DIFF_W'(cmd_reg.cy) - DIFF_W'(cmd_reg.ay);
    assign d_cax = DIFF_W'(cmd_reg.cx) - DIFF_W'(cmd_reg.ax);
    assign d_bay = DIFF_W'(cmd_reg.by) - DIFF_W'(cmd_reg.ay);

    assign area = AREA_W'(prod_a_reg) - AREA_W'(prod_b_reg);

    // bounding box clipped to the frame
    always_comb
    begin
        xmin = min3(cmd_reg.ax, cmd_reg.bx, cmd_reg.cx);
        xmax = max3(cmd_reg.ax, cmd_reg.bx, cmd_reg.cx);
        ymin = min3(cmd_reg.ay, cmd_reg.by, cmd_reg.cy);
        ymax = max3(cmd_reg.ay, cmd_reg.by, cmd_reg.cy);
        x0c  = (xmin < 0) ? '0 : xmin;
        y0c  = (ymin < 0) ? '0 : ymin;
        x1c  = (xmax > FRAME_X_MAX) ? FRAME_X_MAX : xmax;
        y1c  = (ymax > FRAME_Y_MAX) ? FRAME_Y_MAX : ymax;
    end

    always_comb
    begin
        push_cmd           = cmd_reg;
        push_cmd.culled    = !cmd_reg.is_read && area[AREA_W-1];
        push_cmd.x0        = x0c;
        push_cmd.x1        = x1c;
        push_cmd.y0        = y0c;
        push_cmd.y1        = y1c;
        push_cmd.box_empty = (x0c > x1c) || (y0c > y1c);
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        push        = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cmd_next.is_read   = (req.mode == MODE_READ);
                    cmd_next.culled    = 1'b0;
                    cmd_next.box_empty = 1'b0;
                    cmd_next.read_x    = req.read_x;
                    cmd_next.read_y    = req.read_y;
                    cmd_next.ax        = req.ax;
                    cmd_next.ay        = req.ay;
                    cmd_next.bx        = req.bx;
                    cmd_next.by        = req.by;
                    cmd_next.cx        = req.cx;
                    cmd_next.cy        = req.cy;
                    cmd_next.x0        = '0;
                    cmd_next.x1        = '0;
                    cmd_next.y0        = '0;
                    cmd_next.y1        = '0;
                    cmd_next.color     = req.fill_color;
                    state_next = (req.mode == MODE_READ) ? F_PUSH : F_PROD_A;
                end
            end
            F_PROD_A:
            begin
                prod_a_next = d_bax * d_cay;
                state_next  = F_PROD_B;
            end
            F_PROD_B:
            begin
                prod_b_next = d_cax * d_bay;
                state_next  = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
    end

`ifndef NO_ASSERTIONS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into a full queue");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != F_IDLE))
        else $error("front end idle right after a transfer");

    a_read_never_culled: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.is_read) |-> !push_cmd.culled)
        else $error("read command marked culled");
`endif

endmodule

`default_nettype wire

@@ hdl/ftr_cmd_queue.sv @@
`default_nettype none

module ftr_cmd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ftr_pkg::cmd_t    push_cmd,
    input  wire logic             pop,
    output ftr_pkg::cmd_t         head,
    output ftr_pkg::q_stat_t      q_stat
);
    import ftr_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head         = slot_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    a_empty_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue both empty and full");
`endif

endmodule

`default_nettype wire

@@ hdl/ftr_back.sv @@
`default_nettype none

module ftr_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ftr_pkg::q_stat_t q_stat,
    input  wire ftr_pkg::cmd_t    head,
    output logic                  pop,
    output logic                  clearing,
    ftr_rsp_if.source             rsp
);
    import ftr_pkg::*;

    typedef enum logic [6:0] {
        B_CLEAR  = 7'b0000001,
        B_IDLE   = 7'b0000010,
        B_DECODE = 7'b0000100,
        B_SETUP  = 7'b0001000,
        B_SCAN   = 7'b0010000,
        B_VERT   = 7'b0100000,
        B_RESULT = 7'b1000000
    } bstate_t;

    localparam logic [1:0] EDGE_BC = 2'd0;
    localparam logic [1:0] EDGE_CA = 2'd1;
    localparam logic [1:0] EDGE_AB = 2'd2;
    localparam logic [1:0] VTX_A   = 2'd0;
    localparam logic [1:0] VTX_B   = 2'd1;
    localparam logic [1:0] VTX_C   = 2'd2;
    localparam logic [2:0] SETUP_LAST = 3'd6;

    bstate_t                  state_reg, state_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [2:0]               scnt_reg, scnt_next;
    logic [1:0]               vcnt_reg, vcnt_next;
    logic                     out_valid_reg, out_valid_next;

    cmd_t                     cmd_reg, cmd_next;
    logic [XW-1:0]            x_reg, x_next;
    logic [YW-1:0]            y_reg, y_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [EDGE_W-1:0] e_row_reg [3];
    logic signed [EDGE_W-1:0] e_row_next [3];
    logic signed [EDGE_W-1:0] e_cur_reg [3];
    logic signed [EDGE_W-1:0] e_cur_next [3];
    logic [COLOR_W-1:0]       out_color_reg, out_color_next;
    logic                     out_culled_reg, out_culled_next;

    logic [COLOR_W-1:0]       frame_mem [MEM_DEPTH];
    logic [COLOR_W-1:0]       rdata_reg;
    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic [COLOR_W-1:0]       mem_wdata;

    logic signed [EDGE_W-1:0] step_x [3];
    logic signed [EDGE_W-1:0] step_y [3];
    logic [1:0]               mul_edge;
    logic [2:0]               acc_step;
    logic [1:0]               acc_edge;
    coord_t                   qx, qy, rx, ry, vx, vy;
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic                     fill;
    logic                     rd_in_range;
    logic                     out_load;
    logic [XW-1:0]            x_first, x_last;
    logic [YW-1:0]            y_first, y_last;

    assign clearing = (state_reg == B_CLEAR);

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_color = out_color_reg;
    assign rsp.was_culled = out_culled_reg;

    assign x_first = XW'(cmd_reg.x0);
    assign x_last  = XW'(cmd_reg.x1);
    assign y_first = YW'(cmd_reg.y0);
    assign y_last  = YW'(cmd_reg.y1);

    assign rd_in_range = (int'(cmd_reg.read_x) < FRAME_WIDTH) &&
                         (int'(cmd_reg.read_y) < FRAME_HEIGHT);

    // per-column and per-row increments of the edge functions of edges BC, CA and AB
    assign step_x[0] = EDGE_W'(cmd_reg.by) - EDGE_W'(cmd_reg.cy);
    assign step_y[0] = EDGE_W'(cmd_reg.cx) - EDGE_W'(cmd_reg.bx);
    assign step_x[1] = EDGE_W'(cmd_reg.cy) - EDGE_W'(cmd_reg.ay);
    assign step_y[1] = EDGE_W'(cmd_reg.ax) - EDGE_W'(cmd_reg.cx);
    assign step_x[2] = EDGE_W'(cmd_reg.ay) - EDGE_W'(cmd_reg.by);
    assign step_y[2] = EDGE_W'(cmd_reg.bx) - EDGE_W'(cmd_reg.ax);

    // setup runs six products through one multiplier, two per edge
    assign mul_edge = scnt_reg[2:1];
    assign acc_step = scnt_reg - 3'd1;
    assign acc_edge = acc_step[2:1];

    always_comb
    begin
        unique case (mul_edge)
            EDGE_BC:
            begin
                qx = cmd_reg.bx; qy = cmd_reg.by; rx = cmd_reg.cx; ry = cmd_reg.cy;
            end
            EDGE_CA:
            begin
                qx = cmd_reg.cx; qy = cmd_reg.cy; rx = cmd_reg.ax; ry = cmd_reg.ay;
            end
            default:
            begin
                qx = cmd_reg.ax; qy = cmd_reg.ay; rx = cmd_reg.bx; ry = cmd_reg.by;
            end
        endcase
    end

    always_comb
    begin
        if (scnt_reg[0])
        begin
            mul_a = DIFF_W'(rx) - DIFF_W'(cmd_reg.x0);
            mul_b = DIFF_W'(qy) - DIFF_W'(cmd_reg.y0);
        end
        else
        begin
            mul_a = DIFF_W'(qx) - DIFF_W'(cmd_reg.x0);
            mul_b = DIFF_W'(ry) - DIFF_W'(cmd_reg.y0);
        end
    end

    always_comb
    begin
        unique case (vcnt_reg)
            VTX_A:
            begin
                vx = cmd_reg.ax; vy = cmd_reg.ay;
            end
            VTX_B:
            begin
                vx = cmd_reg.bx; vy = cmd_reg.by;
            end
            default:
            begin
                vx = cmd_reg.cx; vy = cmd_reg.cy;
            end
        endcase
    end

    // filled when the BC, CA and AB edge values share a sign, zero taken as non-negative
    assign fill = (e_cur_reg[0][EDGE_W-1] == e_cur_reg[1][EDGE_W-1]) &&
                  (e_cur_reg[1][EDGE_W-1] == e_cur_reg[2][EDGE_W-1]);

    assign out_load = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        scnt_next       = scnt_reg;
        vcnt_next       = vcnt_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        prod_next       = prod_reg;
        out_color_next  = out_color_reg;
        out_culled_next = out_culled_reg;
        for (int i = 0; i < 3; i++)
        begin
            e_row_next[i] = e_row_reg[i];
            e_cur_next[i] = e_cur_reg[i];
        end
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pix_addr(x_reg, y_reg);
        mem_wdata = cmd_reg.color;
        mem_re    = 1'b0;
        mem_raddr = pix_addr(XW'(cmd_reg.read_x), YW'(cmd_reg.read_y));

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = PIX_CLEAR;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = B_DECODE;
                end
            end
            B_DECODE:
            begin
                if (cmd_reg.is_read)
                begin
                    mem_re     = 1'b1;
                    state_next = B_RESULT;
                end
                else if (cmd_reg.culled)
                begin
                    state_next = B_RESULT;
                end
                else if (cmd_reg.box_empty)
                begin
                    vcnt_next  = VTX_A;
                    state_next = B_VERT;
                end
                else
                begin
                    x_next    = x_first;
                    y_next    = y_first;
                    scnt_next = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        e_row_next[i] = '0;
                        e_cur_next[i] = '0;
                    end
                    state_next = B_SETUP;
                end
            end
            B_SETUP:
            begin
                prod_next = mul_a * mul_b;
                if (scnt_reg != 3'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (acc_edge == 2'(i))
                        begin
                            if (acc_step[0])
                            begin
                                e_row_next[i] = e_row_reg[i] - EDGE_W'(prod_reg);
                                e_cur_next[i] = e_cur_reg[i] - EDGE_W'(prod_reg);
                            end
                            else
                            begin
                                e_row_next[i] = e_row_reg[i] + EDGE_W'(prod_reg);
                                e_cur_next[i] = e_cur_reg[i] + EDGE_W'(prod_reg);
                            end
                        end
                    end
                end
                scnt_next = scnt_reg + 3'd1;
                if (scnt_reg == SETUP_LAST)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                mem_we = fill;
                if (x_reg == x_last)
                begin
                    if (y_reg == y_last)
                    begin
                        vcnt_next  = VTX_A;
                        state_next = B_VERT;
                    end
                    else
                    begin
                        x_next = x_first;
                        y_next = y_reg + 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            e_row_next[i] = e_row_reg[i] + step_y[i];
                            e_cur_next[i] = e_row_reg[i] + step_y[i];
                        end
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        e_cur_next[i] = e_cur_reg[i] + step_x[i];
                    end
                end
            end
            B_VERT:
            begin
                mem_we    = in_frame(vx, vy);
                mem_waddr = pix_addr(XW'(vx), YW'(vy));
                mem_wdata = PIX_WHITE;
                vcnt_next = vcnt_reg + 2'd1;
                if (vcnt_reg == VTX_C)
                begin
                    state_next = B_RESULT;
                end
            end
            B_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_color_next  = (cmd_reg.is_read && rd_in_range) ? rdata_reg : '0;
                    out_culled_next = !cmd_reg.is_read && cmd_reg.culled;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            scnt_reg      <= '0;
            vcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scnt_reg      <= scnt_next;
            vcnt_reg      <= vcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        prod_reg       <= prod_next;
        out_color_reg  <= out_color_next;
        out_culled_reg <= out_culled_next;
        for (int i = 0; i < 3; i++)
        begin
            e_row_reg[i] <= e_row_next[i];
            e_cur_reg[i] <= e_cur_next[i];
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= frame_mem[mem_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_DECODE))
        else $error("popped command not decoded");

    a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SCAN) |-> ((x_reg <= x_last) && (y_reg <= y_last)))
        else $error("scan position outside bounding box");

    a_culled_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_culled_reg) |-> (out_color_reg == '0))
        else $error("culled result carries a colour");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_RESULT) && out_load) |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule

`default_nettype wire

@@ hdl/flat_triangle_edge_rasterizer.sv @@
// flat-shaded triangle rasteriser with a 256 x 256 x 32-bit frame store
//
// req channel: mode 0 draws triangle a/b/c in fill_color, mode 1 reads the
// pixel at read_x/read_y. rsp channel: exactly one result per transfer on req,
// in order; read_color holds the pixel for reads, was_culled flags a triangle
// with negative signed area (nothing drawn).
// a front end takes one transfer at a time, works out area and clipped
// bounding box, and queues a command; the back end runs commands one at a time.
// read: the back end pops it, reads the frame store and presents the pixel.
// draw: area products, back-end setup, a scan of the clipped bounding box at one
// pixel per cycle and white vertex marks; culled triangles skip setup, scan and marks.
// after reset the back end sweeps the frame store to zero, one pixel a cycle,
// and req.ready stays low until the sweep is done.
// when the receiver stalls the result waits in the output register; the back end,
// the queue and the front end take up to four more items before req.ready stays low.
`default_nettype none

module flat_triangle_edge_rasterizer (
    input  wire logic clk,
    input  wire logic rst_n,
    ftr_req_if.sink   req,
    ftr_rsp_if.source rsp
);
    import ftr_pkg::*;

    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head;
    q_stat_t q_stat;
    logic    clearing;

    ftr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .clearing (clearing),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ftr_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ftr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

@@ verif/tb_flat_triangle_edge_rasterizer.sv @@
`default_nettype none

module tb_flat_triangle_edge_rasterizer;
    import ftr_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL   = 40;
    localparam int STALL_LIMIT  = 280000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        mode_t              mode;
        coord_t             ax;
        coord_t             ay;
        coord_t             bx;
        coord_t             by;
        coord_t             cx;
        coord_t             cy;
        logic [COLOR_W-1:0] fill_color;
        logic [READ_W-1:0]  read_x;
        logic [READ_W-1:0]  read_y;
    } raster_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               was_culled;
    } raster_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    ftr_req_if req_ch ();
    ftr_rsp_if rsp_ch ();

    flat_triangle_edge_rasterizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    raster_req_t        pending_req[$];
    raster_rsp_t        due_results[$];
    logic [COLOR_W-1:0] shadow_frame[MEM_DEPTH];

    raster_req_t cur_req;
    int          total_items;
    int          sent_cnt;
    int          recv_cnt;
    int          fail_cnt;
    int          n_draws;
    int          n_culled;
    int          n_reads;
    longint      n_painted;
    int          tx_gap;
    int          rx_gap;
    int          quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint edge_val(input longint px, input longint py,
                                        input longint qx, input longint qy,
                                        input longint rx, input longint ry);
        return (qx - px) * (ry - py) - (rx - px) * (qy - py);
    endfunction

    function automatic longint tri_area(input raster_req_t t);
        return edge_val(longint'($signed(t.ax)), longint'($signed(t.ay)),
                        longint'($signed(t.bx)), longint'($signed(t.by)),
                        longint'($signed(t.cx)), longint'($signed(t.cy)));
    endfunction

    // bounding box clipped to the frame, empty when lo > hi
    function automatic void clip_box(input raster_req_t t,
                                     output longint x0, output longint x1,
                                     output longint y0, output longint y1);
        longint ax, ay, bx, by, cx, cy;
        ax = longint'($signed(t.ax));
        ay = longint'($signed(t.ay));
        bx = longint'($signed(t.bx));
        by = longint'($signed(t.by));
        cx = longint'($signed(t.cx));
        cy = longint'($signed(t.cy));
        x0 = (ax < bx) ? ax : bx;
        x0 = (x0 < cx) ? x0 : cx;
        x1 = (ax > bx) ? ax : bx;
        x1 = (x1 > cx) ? x1 : cx;
        y0 = (ay < by) ? ay : by;
        y0 = (y0 < cy) ? y0 : cy;
        y1 = (ay > by) ? ay : by;
        y1 = (y1 > cy) ? y1 : cy;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > FRAME_WIDTH - 1) x1 = FRAME_WIDTH - 1;
        if (y1 > FRAME_HEIGHT - 1) y1 = FRAME_HEIGHT - 1;
    endfunction

    function automatic longint box_pixels(input raster_req_t t);
        longint x0, x1, y0, y1;
        clip_box(t, x0, x1, y0, y1);
        if (x0 > x1 || y0 > y1)
            return 0;
        return (x1 - x0 + 1) * (y1 - y0 + 1);
    endfunction

    function automatic void paint(input longint x, input longint y,
                                  input logic [COLOR_W-1:0] c);
        if (x >= 0 && y >= 0 && x < FRAME_WIDTH && y < FRAME_HEIGHT)
            shadow_frame[y * FRAME_WIDTH + x] = c;
    endfunction

    // updates the shadow frame and queues the result the block owes for t
    function automatic void predict_raster(input raster_req_t t);
        raster_rsp_t r;
        longint      ax, ay, bx, by, cx, cy;
        longint      x0, x1, y0, y1, x, y;
        logic        n0, n1, n2;
        r = '0;
        if (t.mode == MODE_READ) begin
            n_reads++;
            r.read_color = shadow_frame[int'(t.read_y) * FRAME_WIDTH + int'(t.read_x)];
        end
        else if (tri_area(t) < 0) begin
            n_draws++;
            n_culled++;
            r.was_culled = 1'b1;
        end
        else begin
            n_draws++;
            ax = longint'($signed(t.ax));
            ay = longint'($signed(t.ay));
            bx = longint'($signed(t.bx));
            by = longint'($signed(t.by));
            cx = longint'($signed(t.cx));
            cy = longint'($signed(t.cy));
            clip_box(t, x0, x1, y0, y1);
            for (x = x0; x <= x1; x++) begin
                for (y = y0; y <= y1; y++) begin
                    n0 = edge_val(x, y, bx, by, cx, cy) < 0;
                    n1 = edge_val(x, y, cx, cy, ax, ay) < 0;
                    n2 = edge_val(x, y, ax, ay, bx, by) < 0;
                    if (n0 == n1 && n1 == n2) begin
                        paint(x, y, t.fill_color);
                        n_painted++;
                    end
                end
            end
            paint(ax, ay, PIX_WHITE);
            paint(bx, by, PIX_WHITE);
            paint(cx, cy, PIX_WHITE);
        end
        due_results.push_back(r);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t coord_in(input int lo, input int hi);
        return coord_t'(lo + int'($urandom_range(hi - lo)));
    endfunction

    // unused fields carry random junk
    function automatic raster_req_t make_read(input int x, input int y);
        raster_req_t t;
        t.mode       = MODE_READ;
        t.ax         = any_coord();
        t.ay         = any_coord();
        t.bx         = any_coord();
        t.by         = any_coord();
        t.cx         = any_coord();
        t.cy         = any_coord();
        t.fill_color = $urandom;
        t.read_x     = READ_W'(x);
        t.read_y     = READ_W'(y);
        return t;
    endfunction

    function automatic raster_req_t make_draw(input int ax, input int ay,
                                              input int bx, input int by,
                                              input int cx, input int cy,
                                              input logic [COLOR_W-1:0] c);
        raster_req_t t;
        t.mode       = MODE_DRAW;
        t.ax         = coord_t'(ax);
        t.ay         = coord_t'(ay);
        t.bx         = coord_t'(bx);
        t.by         = coord_t'(by);
        t.cx         = coord_t'(cx);
        t.cy         = coord_t'(cy);
        t.fill_color = c;
        t.read_x     = READ_W'($urandom);
        t.read_y     = READ_W'($urandom);
        return t;
    endfunction

    // queue a draw and then n reads in its clipped box (anywhere if it is empty)
    function automatic void push_draw_and_probe(input raster_req_t t, input int n);
        longint x0, x1, y0, y1;
        int     k;
        pending_req.push_back(t);
        clip_box(t, x0, x1, y0, y1);
        for (k = 0; k < n; k++) begin
            if (x0 > x1 || y0 > y1)
                pending_req.push_back(make_read($urandom_range(255), $urandom_range(255)));
            else
                pending_req.push_back(make_read(int'(x0) + $urandom_range(int'(x1 - x0)),
                                                int'(y0) + $urandom_range(int'(y1 - y0))));
        end
    endfunction

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            tx_gap       <= 0;
            sent_cnt     <= 0;
        end
        else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_raster(cur_req);
                sent_cnt <= sent_cnt + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap       <= tx_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_req.size() > 0) begin
                    cur_req = pending_req.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.mode       <= cur_req.mode;
                    req_ch.ax         <= cur_req.ax;
                    req_ch.ay         <= cur_req.ay;
                    req_ch.bx         <= cur_req.bx;
                    req_ch.by         <= cur_req.by;
                    req_ch.cx         <= cur_req.cx;
                    req_ch.cy         <= cur_req.cy;
                    req_ch.fill_color <= cur_req.fill_color;
                    req_ch.read_x     <= cur_req.read_x;
                    req_ch.read_y     <= cur_req.read_y;
                    // stretches of back-to-back items come from the random gate
                    if (sent_cnt < total_items - QUIET_TAIL && $urandom_range(3) == 0)
                        tx_gap <= $urandom_range(1, 4);
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        raster_rsp_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rx_gap       <= 0;
            recv_cnt     <= 0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                recv_cnt <= recv_cnt + 1;
                if (due_results.size() == 0) begin
                    $error("result with nothing outstanding: read_color %08h was_culled %0b",
                           rsp_ch.read_color, rsp_ch.was_culled);
                    fail_cnt++;
                end
                else begin
                    want = due_results.pop_front();
                    if (rsp_ch.read_color !== want.read_color) begin
                        $error("read_color: expected %08h, got %08h",
                               want.read_color, rsp_ch.read_color);
                        fail_cnt++;
                    end
                    if (rsp_ch.was_culled !== want.was_culled) begin
                        $error("was_culled: expected %0b, got %0b",
                               want.was_culled, rsp_ch.was_culled);
                        fail_cnt++;
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap       <= rx_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
                if (sent_cnt < total_items - QUIET_TAIL && $urandom_range(4) == 0)
                    rx_gap <= $urandom_range(1, 4);
            end
        end
    end

    // the clearing sweep after reset and a full-frame scan both fit well inside
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d of %0d items sent",
                         quiet_cycles, sent_cnt, total_items);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        raster_req_t t;
        int          pick;
        int          big_left;
        int          bx0, by0, span, dx, dy;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_DRAW;
        req_ch.ax         = '0;
        req_ch.ay         = '0;
        req_ch.bx         = '0;
        req_ch.by         = '0;
        req_ch.cx         = '0;
        req_ch.cy         = '0;
        req_ch.fill_color = '0;
        req_ch.read_x     = '0;
        req_ch.read_y     = '0;
        rsp_ch.ready      = 1'b0;
        total_items       = 1 << 30;
        fail_cnt          = 0;
        n_draws           = 0;
        n_culled          = 0;
        n_reads           = 0;
        n_painted         = 0;
        quiet_cycles      = 0;
        for (int i = 0; i < MEM_DEPTH; i++)
            shadow_frame[i] = PIX_CLEAR;

        // directed: cleared frame, plain fill, culling, degenerate shapes, clipping
        pending_req.push_back(make_read(0, 0));
        pending_req.push_back(make_read(255, 255));
        pending_req.push_back(make_draw(10, 10, 20, 10, 10, 20, 32'h1122_3344));
        pending_req.push_back(make_read(12, 12));
        pending_req.push_back(make_read(10, 10));
        pending_req.push_back(make_read(19, 19));
        pending_req.push_back(make_draw(10, 10, 10, 20, 20, 10, 32'hDEAD_BEEF));
        pending_req.push_back(make_read(11, 11));
        pending_req.push_back(make_draw(30, 30, 40, 40, 50, 50, 32'h00FF_00FF));
        pending_req.push_back(make_read(35, 35));
        pending_req.push_back(make_read(36, 35));
        pending_req.push_back(make_draw(60, 60, 60, 60, 60, 60, 32'h0000_0000));
        pending_req.push_back(make_draw(-5, -5, 10, -5, -5, 10, 32'h0F0F_0F0F));
        pending_req.push_back(make_read(0, 0));
        pending_req.push_back(make_draw(250, 250, 300, 250, 250, 300, 32'hA5A5_A5A5));
        pending_req.push_back(make_read(255, 255));
        pending_req.push_back(make_draw(1000, 1000, 1023, 1000, 1000, 1023, 32'h1234_5678));
        pending_req.push_back(make_draw(-1024, -1024, 1023, -1024, 1023, 1023, 32'h8000_0001));
        pending_req.push_back(make_read(200, 10));
        pending_req.push_back(make_read(0, 255));
        pending_req.push_back(make_draw(-1024, -1024, 1023, 1023, 1023, -1024, 32'hFFFF_FFFF));
        pending_req.push_back(make_read(255, 0));
        pending_req.push_back(make_read(128, 128));

        big_left = 3;
        total_items = pending_req.size() + RANDOM_ITEMS;
        while (pending_req.size() < total_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // small triangle near or inside the frame, either winding
                bx0 = -8 + int'($urandom_range(271));
                by0 = -8 + int'($urandom_range(271));
                t = make_draw(bx0 + $urandom_range(15), by0 + $urandom_range(15),
                              bx0 + $urandom_range(15), by0 + $urandom_range(15),
                              bx0 + $urandom_range(15), by0 + $urandom_range(15),
                              $urandom);
                push_draw_and_probe(t, $urandom_range(1, 3));
            end
            else if (pick < 60) begin
                pending_req.push_back(make_read($urandom_range(255), $urandom_range(255)));
            end
            else if (pick < 75) begin
                // full-range vertices, kept cheap: culled or a small clipped box
                do begin
                    t = make_draw(0, 0, 0, 0, 0, 0, $urandom);
                    t.ax = any_coord();
                    t.ay = any_coord();
                    t.bx = any_coord();
                    t.by = any_coord();
                    t.cx = any_coord();
                    t.cy = any_coord();
                end while (tri_area(t) >= 0 && box_pixels(t) > 1024);
                push_draw_and_probe(t, $urandom_range(0, 1));
            end
            else if (pick < 85) begin
                // collinear or coincident vertices
                bx0 = int'($urandom_range(255));
                by0 = int'($urandom_range(255));
                dx  = int'($urandom_range(16)) - 8;
                dy  = int'($urandom_range(16)) - 8;
                if ($urandom_range(3) == 0)
                    t = make_draw(bx0, by0, bx0, by0, bx0 + dx, by0 + dy, $urandom);
                else
                    t = make_draw(bx0, by0, bx0 + dx, by0 + dy, bx0 + 2 * dx, by0 + 2 * dy,
                                  $urandom);
                push_draw_and_probe(t, $urandom_range(1, 2));
            end
            else if (pick < 95 || big_left == 0) begin
                span = 40;
                bx0  = int'($urandom_range(255 - span));
                by0  = int'($urandom_range(255 - span));
                t = make_draw(bx0 + $urandom_range(span), by0 + $urandom_range(span),
                              bx0 + $urandom_range(span), by0 + $urandom_range(span),
                              bx0 + $urandom_range(span), by0 + $urandom_range(span),
                              $urandom);
                push_draw_and_probe(t, $urandom_range(1, 3));
            end
            else begin
                // a few big ones that sweep most of the frame
                big_left--;
                t = make_draw(coord_in(-300, 560), coord_in(-300, 560),
                              coord_in(-300, 560), coord_in(-300, 560),
                              coord_in(-300, 560), coord_in(-300, 560), $urandom);
                if (tri_area(t) < 0) begin
                    t.bx = t.cx;
                    t.by = t.cy;
                    t = make_draw(t.ax, t.ay, t.bx, t.by,
                                  pending_req.size() % 2 ? -300 : 560, 560, t.fill_color);
                end
                push_draw_and_probe(t, 3);
            end
        end
        // the loop may overshoot by a few reads
        total_items = pending_req.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt < total_items)
            @(posedge clk);
        while (due_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d triangles (%0d culled, %0d pixels filled) and %0d pixel reads",
                 n_draws, n_culled, n_painted, n_reads);
        $display("%0d results checked, %0d mismatches", recv_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/ftr_pkg.sv
hdl/ftr_req_if.sv
hdl/ftr_rsp_if.sv
hdl/ftr_front.sv
hdl/ftr_cmd_queue.sv
hdl/ftr_back.sv
hdl/flat_triangle_edge_rasterizer.sv
verif/tb_flat_triangle_edge_rasterizer.sv
